@@ hdl/lobm_pkg.sv @@
// Package for the limit order book matcher: opcodes, status codes, shared types.
// No dependencies.
package lobm_pkg;

  localparam logic [1:0] OP_MARKET = 2'd0;
  localparam logic [1:0] OP_LIMIT  = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;

  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_RESTED   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_CANCELED = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // slot index width on the search chain, covers up to 64 slots
  localparam int IDX_W = 6;

  // resting entry content
  typedef struct packed {
    logic        side;
    logic [63:0] symbol;
    logic [31:0] seq;
    logic [63:0] price;
    logic [31:0] qty;
  } entry_t;

  // key carried along the search chain
  typedef struct packed {
    logic             found;
    logic [63:0]      pkey;
    logic [31:0]      skey;
    logic [IDX_W-1:0] idx;
  } cand_t;

  // per-cell write command from the controller
  typedef struct packed {
    logic        wr;
    logic        clr;
    logic        setq;
    logic [31:0] qty;
    entry_t      data;
  } cell_cmd_t;

endpackage

@@ hdl/limit_order_book_matcher.sv @@
// Limit order book matcher top level: controller, cell chain, entry read.
// Depends on lobm_pkg and lobm_cell.
//
// Price-time priority book of BOOK_DEPTH resting orders kept in a row of
// cells. Each search (best opposite order or exact key) walks a registered
// candidate down the chain one cell per cycle, then the decide state acts on
// the result. A fill that leaves quantity open passes through the drain
// state so the cell update lands before the next search, and the decide state
// waits while the output register still holds an unaccepted transaction. A
// market/limit order with f fills runs f searches if its quantity runs out,
// else f+1 (the last one finds nothing or stops at the limit price); a limit
// remainder adds one exact search and the place state (the free-slot pick is
// combinational). A cancel takes one search. The final status leaves from the
// emit state. Results leave through an output register, one per transaction.
// Only one order is in work at a time; the next input is taken after the
// final status transaction is handed off.
module limit_order_book_matcher import lobm_pkg::*; #(
  parameter int BOOK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic        side,
  input  logic [63:0] symbol,
  input  logic signed [31:0] seq_num,
  input  logic [31:0] quantity,
  input  logic signed [63:0] price,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [31:0] trade_number,
  output logic signed [31:0] buy_seq,
  output logic signed [31:0] sell_seq,
  output logic [31:0] fill_quantity,
  output logic signed [63:0] exec_price,
  output logic [63:0] trade_symbol,
  output logic [2:0]  status,
  output logic [31:0] remaining,
  output logic        last
);

  localparam int CW = $clog2(BOOK_DEPTH + 2);
  localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_EXACT  = 7'b0001000,
    S_PLACE  = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_DRAIN  = 7'b1000000
  } state_t;

  state_t state;
  logic [1:0]  op_r;
  entry_t      ord;      // incoming order; qty holds what is still open
  logic        exact_mode;
  logic [CW-1:0] cnt;
  logic [31:0] tcount;
  cand_t       res;

  cell_cmd_t   cmds [BOOK_DEPTH];
  cand_t       chain [BOOK_DEPTH+1];
  logic [BOOK_DEPTH-1:0] vbits;
  entry_t      key;

  // one registered cell command per cycle, steered to its slot
  cell_cmd_t     cmd_r, cmd_next;
  logic [IW-1:0] cmd_slot, slot_next;

  // shadow copy of entries for reading the chosen slot
  entry_t      shadow [BOOK_DEPTH];
  entry_t      best_e;

  assign key = '{side: (exact_mode ? ord.side : ~ord.side), symbol: ord.symbol,
                 seq: ord.seq, price: ord.price, qty: ord.qty};
  assign chain[0] = '0;

  genvar g;
  generate
    for (g = 0; g < BOOK_DEPTH; g++) begin : g_cell
      assign cmds[g] = (cmd_slot == IW'(g)) ? cmd_r : '0;
      lobm_cell #(.INDEX(g)) u_cell (
        .clk(clk), .rst(rst), .cmd(cmds[g]), .mode_exact(exact_mode), .key(key),
        .cand_in(chain[g]), .cand_out(chain[g+1]), .valid_out(vbits[g])
      );
    end
  endgenerate

  // first free slot
  logic          free_found;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
      if (!vbits[i]) begin
        free_found = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  // output register
  logic        o_kind;
  logic [31:0] o_tn, o_bs, o_ss, o_fq, o_rem;
  logic [63:0] o_ep, o_sym;
  logic [2:0]  o_st;
  logic        o_last;
  assign kind = o_kind; assign trade_number = o_tn; assign buy_seq = o_bs;
  assign sell_seq = o_ss; assign fill_quantity = o_fq; assign exec_price = o_ep;
  assign trade_symbol = o_sym; assign status = o_st; assign remaining = o_rem;
  assign last = o_last;

  assign in_ready = (state == S_IDLE) && !out_valid;

  logic [31:0] fill;
  logic        price_stop;
  logic [63:0] ok, bk;
  assign ok = ord.price ^ 64'h8000_0000_0000_0000;
  assign bk = best_e.price ^ 64'h8000_0000_0000_0000;
  assign price_stop = (op_r == OP_LIMIT) && (ord.side ? ok > bk : ok < bk);
  assign fill = (ord.qty < best_e.qty) ? ord.qty : best_e.qty;

  logic [2:0] st_pend;

  // cell command: cancel hit, fill update, or resting write
  always_comb begin
    cmd_next = '0;
    slot_next = res.idx[IW-1:0];
    if (state == S_DECIDE && op_r == OP_CANCEL) begin
      cmd_next.clr = res.found;
    end else if (state == S_DECIDE && !exact_mode && res.found && !price_stop &&
                 !out_valid) begin
      if (best_e.qty == fill) begin
        cmd_next.clr = 1'b1;
      end else begin
        cmd_next.setq = 1'b1;
        cmd_next.qty = best_e.qty - fill;
      end
    end else if (state == S_PLACE && (res.found || free_found)) begin
      cmd_next.wr = 1'b1;
      cmd_next.data = ord;
      if (!res.found) slot_next = free_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_r <= '0;
      cmd_slot <= '0;
    end else begin
      cmd_r <= cmd_next;
      cmd_slot <= slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      tcount <= '0;
      exact_mode <= 1'b0;
      cnt <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op_r <= opcode;
            ord <= '{side: side, symbol: symbol, seq: seq_num, price: price,
                     qty: (opcode == OP_MARKET || opcode == OP_LIMIT) ?
                          quantity : 32'd0};
            cnt <= '0;
            if (opcode == OP_CANCEL) begin
              exact_mode <= 1'b1;
              state <= S_SEARCH;
            end else if (opcode == OP_MARKET || opcode == OP_LIMIT) begin
              exact_mode <= 1'b0;
              state <= (quantity == '0) ? S_EMIT : S_SEARCH;
              st_pend <= ST_NONE;
            end else begin
              st_pend <= ST_NONE;
              state <= S_EMIT;
            end
          end
        end
        S_SEARCH: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(BOOK_DEPTH)) begin
            res <= chain[BOOK_DEPTH];
            best_e <= shadow[chain[BOOK_DEPTH].idx[IW-1:0]];
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          cnt <= '0;
          if (op_r == OP_CANCEL) begin
            st_pend <= res.found ? ST_CANCELED : ST_NOTFOUND;
            ord.qty <= '0;
            state <= S_EMIT;
          end else if (!exact_mode) begin
            if (res.found && !price_stop && !out_valid) begin
              o_kind <= 1'b0; o_tn <= tcount;
              o_bs <= ord.side ? best_e.seq : ord.seq;
              o_ss <= ord.side ? ord.seq : best_e.seq;
              o_fq <= fill; o_ep <= best_e.price; o_sym <= ord.symbol;
              o_st <= ST_NONE; o_rem <= '0; o_last <= 1'b0;
              out_valid <= 1'b1;
              tcount <= tcount + 1'b1;
              ord.qty <= ord.qty - fill;
              shadow[res.idx[IW-1:0]].qty <= best_e.qty - fill;
              state <= (ord.qty == fill) ? S_EMIT : S_DRAIN;
              st_pend <= ST_NONE;
            end else if (!(res.found && !price_stop)) begin
              if (op_r == OP_LIMIT) begin
                exact_mode <= 1'b1;
                state <= S_EXACT;
              end else begin
                st_pend <= ST_NONE;
                state <= S_EMIT;
              end
            end
          end else begin
            state <= S_PLACE;
          end
        end
        S_DRAIN: begin
          // lets the registered cell writes land before the next search
          state <= S_SEARCH;
        end
        S_EXACT: begin
          state <= S_SEARCH;
        end
        S_PLACE: begin
          if (res.found || free_found) begin
            shadow[res.found ? res.idx[IW-1:0] : free_idx] <= ord;
            st_pend <= ST_RESTED;
          end else begin
            st_pend <= ST_FULL;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid) begin
            o_kind <= 1'b1; o_tn <= '0; o_bs <= '0; o_ss <= '0; o_fq <= '0;
            o_ep <= '0; o_sym <= '0; o_st <= st_pend; o_rem <= ord.qty;
            o_last <= 1'b1;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/lobm_cell.sv @@
// One storage cell of the book plus its stage of the best/exact search chain.
// Depends on lobm_pkg.
module lobm_cell import lobm_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  logic      mode_exact,
  input  entry_t    key,
  input  cand_t     cand_in,
  output cand_t     cand_out,
  output logic      valid_out
);

  logic   valid;
  entry_t ent;
  logic   match, better;
  logic [63:0] pk;
  logic [31:0] sk;

  assign pk = ent.price ^ 64'h8000_0000_0000_0000;
  assign sk = ent.seq ^ 32'h8000_0000;
  assign valid_out = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clr) begin
      valid <= 1'b0;
    end else if (cmd.wr) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      ent <= cmd.data;
    end else if (cmd.setq) begin
      ent.qty <= cmd.qty;
    end
  end

  always_comb begin
    match = valid && ent.side == key.side && ent.symbol == key.symbol;
    if (mode_exact) begin
      match = match && ent.price == key.price && ent.seq == key.seq;
      better = match && !cand_in.found;
    end else if (!cand_in.found) begin
      better = match;
    end else begin
      // sell side resting: lowest price; buy side: highest
      better = match && (((key.side ? pk < cand_in.pkey : pk > cand_in.pkey))
               || (pk == cand_in.pkey && sk < cand_in.skey));
    end
  end

  // registered hand-off to the next cell
  always_ff @(posedge clk) begin
    if (better) begin
      cand_out <= '{found: 1'b1, pkey: pk, skey: sk, idx: IDX_W'(INDEX)};
    end else begin
      cand_out <= cand_in;
    end
  end

endmodule

@@ tb/limit_order_book_matcher_tb.sv @@
`timescale 1ns / 100ps
// Testbench for limit_order_book_matcher: directed table plus random order flow,
// checked against an in-bench price-time priority book. Depends on lobm_pkg.
module limit_order_book_matcher_tb;
  import lobm_pkg::*;

  localparam int DEPTH = 32;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // one result transaction
  typedef struct {
    logic        kind;
    logic [31:0] tnum;
    logic [31:0] bseq;
    logic [31:0] sseq;
    logic [31:0] fqty;
    logic [63:0] xprice;
    logic [63:0] tsym;
    logic [2:0]  stat;
    logic [31:0] rem;
    logic        lst;
  } fill_t;

  // one order transaction
  typedef struct {
    logic [1:0]  op;
    logic        sd;
    logic [63:0] sym;
    logic [31:0] seq;
    logic [31:0] qty;
    logic [63:0] px;
    logic        chk;    // typed-in status check
    logic [2:0]  xstat;
  } order_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = '0;
  logic side = 1'b0;
  logic [63:0] symbol = '0;
  logic signed [31:0] seq_num = '0;
  logic [31:0] quantity = '0;
  logic signed [63:0] price = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic [31:0] trade_number;
  logic signed [31:0] buy_seq, sell_seq;
  logic [31:0] fill_quantity;
  logic signed [63:0] exec_price;
  logic [63:0] trade_symbol;
  logic [2:0] status;
  logic [31:0] remaining;
  logic last;

  always #5 clk = ~clk;

  limit_order_book_matcher #(.BOOK_DEPTH(DEPTH)) dut (.*);

  // shadow book
  logic        bk_vld[DEPTH];
  logic        bk_side[DEPTH];
  logic [63:0] bk_sym[DEPTH];
  logic [31:0] bk_seq[DEPTH];
  logic [63:0] bk_px[DEPTH];
  logic [31:0] bk_qty[DEPTH];
  logic [31:0] trade_cnt;

  fill_t pending_fills[$];
  int errors = 0;
  int n_trades = 0, n_status = 0, n_orders = 0;
  int send_idle = 0, recv_stall = 0;  // percent
  logic [2:0] status_typed[$];        // typed status checks, per status line
  logic       status_chk[$];
  logic [31:0] sym_pool[4];

  function automatic int best_resting(logic rs, logic [63:0] sym);
    int b;
    logic [63:0] pi, pb;
    b = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (!bk_vld[i] || bk_side[i] != rs || bk_sym[i] != sym) continue;
      if (b < 0) begin
        b = i;
        continue;
      end
      pi = bk_px[i] ^ 64'h8000_0000_0000_0000;
      pb = bk_px[b] ^ 64'h8000_0000_0000_0000;
      if ((rs ? pi < pb : pi > pb) ||
          (pi == pb && (bk_seq[i] ^ 32'h8000_0000) < (bk_seq[b] ^ 32'h8000_0000)))
        b = i;
    end
    return b;
  endfunction

  function automatic int exact_slot(logic sd, logic [63:0] sym, logic [63:0] px,
                                    logic [31:0] seq);
    for (int i = 0; i < DEPTH; i++)
      if (bk_vld[i] && bk_side[i] == sd && bk_sym[i] == sym && bk_px[i] == px &&
          bk_seq[i] == seq) return i;
    return -1;
  endfunction

  // apply one order to the shadow book and queue its fills and status
  task automatic match_order(order_t o);
    int b, slot;
    logic [31:0] q, f;
    logic [2:0] st;
    fill_t r;
    q = o.qty;
    st = ST_NONE;
    r = '{default: '0};
    if (o.op == OP_CANCEL) begin
      slot = exact_slot(o.sd, o.sym, o.px, o.seq);
      if (slot >= 0) bk_vld[slot] = 1'b0;
      st = (slot >= 0) ? ST_CANCELED : ST_NOTFOUND;
      q = '0;
    end else if (o.op == OP_UNUSED) begin
      q = '0;
    end else begin
      while (q != 0) begin
        b = best_resting(~o.sd, o.sym);
        if (b < 0) break;
        if (o.op == OP_LIMIT) begin
          if (o.sd == 1'b0 ? ((o.px ^ 64'h8000_0000_0000_0000) <
                              (bk_px[b] ^ 64'h8000_0000_0000_0000))
                           : ((o.px ^ 64'h8000_0000_0000_0000) >
                              (bk_px[b] ^ 64'h8000_0000_0000_0000))) break;
        end
        f = (q < bk_qty[b]) ? q : bk_qty[b];
        r = '{default: '0};
        r.kind = KIND_TRADE;
        r.tnum = trade_cnt;
        r.bseq = o.sd ? bk_seq[b] : o.seq;
        r.sseq = o.sd ? o.seq : bk_seq[b];
        r.fqty = f;
        r.xprice = bk_px[b];
        r.tsym = o.sym;
        pending_fills = {pending_fills, r};
        trade_cnt++;
        q -= f;
        bk_qty[b] -= f;
        if (bk_qty[b] == 0) bk_vld[b] = 1'b0;
      end
      if (o.op == OP_LIMIT && q != 0) begin
        slot = exact_slot(o.sd, o.sym, o.px, o.seq);
        if (slot < 0)
          for (int i = 0; i < DEPTH; i++)
            if (!bk_vld[i]) begin
              slot = i;
              break;
            end
        if (slot >= 0) begin
          bk_vld[slot] = 1'b1;
          bk_side[slot] = o.sd;
          bk_sym[slot] = o.sym;
          bk_seq[slot] = o.seq;
          bk_px[slot] = o.px;
          bk_qty[slot] = q;
          st = ST_RESTED;
        end else st = ST_FULL;
      end
    end
    r = '{default: '0};
    r.kind = KIND_STATUS;
    r.stat = st;
    r.rem = q;
    r.lst = 1'b1;
    pending_fills = {pending_fills, r};
    status_chk = {status_chk, o.chk};
    status_typed = {status_typed, o.xstat};
  endtask

  // drive one order; prediction is taken at acceptance
  task automatic send_order(order_t o);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= o.op;
    side <= o.sd;
    symbol <= o.sym;
    seq_num <= o.seq;
    quantity <= o.qty;
    price <= o.px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    match_order(o);
    n_orders++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_fills.size() != 0) @(negedge clk);
  endtask

  // receiver: random stall at each falling edge
  always @(negedge clk)
    if (!rst) out_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);

  // check each result transaction against the oldest prediction
  always @(posedge clk) begin
    fill_t e;
    logic c;
    logic [2:0] ts;
    if (!rst && out_valid && out_ready) begin
      if (pending_fills.size() == 0) begin
        $display("%0t: unexpected result kind=%0d status=%0d", $time, kind, status);
        errors++;
      end else begin
        e = pending_fills.pop_front();
        if ({kind, trade_number, buy_seq, sell_seq, fill_quantity, exec_price,
             trade_symbol, status, remaining, last} !==
            {e.kind, e.tnum, e.bseq, e.sseq, e.fqty, e.xprice, e.tsym, e.stat,
             e.rem, e.lst}) begin
          $display("%0t: mismatch exp kind=%0d tn=%0d b=%0d s=%0d q=%0d px=%0d sym=%h st=%0d rem=%0d last=%0d",
                   $time, e.kind, e.tnum, $signed(e.bseq), $signed(e.sseq), e.fqty,
                   $signed(e.xprice), e.tsym, e.stat, e.rem, e.lst);
          $display("%0t:          got kind=%0d tn=%0d b=%0d s=%0d q=%0d px=%0d sym=%h st=%0d rem=%0d last=%0d",
                   $time, kind, trade_number, buy_seq, sell_seq, fill_quantity,
                   exec_price, trade_symbol, status, remaining, last);
          errors++;
        end
        if (e.kind == KIND_STATUS) begin
          n_status++;
          c = status_chk.pop_front();
          ts = status_typed.pop_front();
          // typed-in value from the directed table
          if (c && status !== ts) begin
            $display("%0t: status exp %0d got %0d", $time, ts, status);
            errors++;
          end
        end else n_trades++;
      end
    end
  end

  // directed table: sym A used for the book walk
  localparam logic [63:0] SYM_A = 64'h4142_4344_2020_2020;
  localparam logic [63:0] PMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PMIN = 64'h8000_0000_0000_0000;
  order_t directed[] = '{
    // empty book: cancel misses, market finds nothing
    '{OP_CANCEL, 1'b0, SYM_A, 32'd1, 32'd0, 64'd5, 1'b1, ST_NOTFOUND},
    '{OP_MARKET, 1'b0, SYM_A, 32'd2, 32'd10, 64'd0, 1'b1, ST_NONE},
    '{OP_LIMIT, 1'b0, SYM_A, 32'd3, 32'd0, 64'd5, 1'b1, ST_NONE},      // zero qty
    '{OP_UNUSED, 1'b1, '1, '1, '1, '1, 1'b1, ST_NONE},
    // asks at extreme prices and sequence numbers
    '{OP_LIMIT, 1'b1, SYM_A, 32'h8000_0000, 32'd5, PMAX, 1'b1, ST_RESTED},
    '{OP_LIMIT, 1'b1, SYM_A, 32'h7FFF_FFFF, 32'd7, 64'd100, 1'b1, ST_RESTED},
    '{OP_LIMIT, 1'b1, SYM_A, 32'h8000_0000, 32'd3, 64'd100, 1'b1, ST_RESTED},
    // same key replaces quantity
    '{OP_LIMIT, 1'b1, SYM_A, 32'h8000_0000, 32'd4, 64'd100, 1'b1, ST_RESTED},
    '{OP_LIMIT, 1'b0, SYM_A, 32'd10, 32'd6, 64'd99, 1'b1, ST_RESTED},  // no cross
    '{OP_LIMIT, 1'b0, SYM_A, 32'd11, 32'd20, 64'd100, 1'b0, ST_NONE},  // crosses
    '{OP_LIMIT, 1'b1, SYM_A, 32'd12, 32'hFFFF_FFFF, PMIN, 1'b0, ST_NONE},
    '{OP_MARKET, 1'b0, SYM_A, 32'd13, 32'hFFFF_FFFF, 64'd0, 1'b0, ST_NONE},
    '{OP_CANCEL, 1'b1, SYM_A, 32'd12, 32'd0, PMIN, 1'b0, ST_NONE},
    '{OP_CANCEL, 1'b1, SYM_A, 32'd12, 32'd0, PMIN, 1'b1, ST_NOTFOUND},
    '{OP_MARKET, 1'b1, '1, 32'd14, 32'd1, PMAX, 1'b0, ST_NONE}
  };

  function automatic order_t rand_order(logic wide);
    order_t o;
    o.chk = 1'b0;
    o.xstat = ST_NONE;
    o.op = ($urandom_range(99) < 3) ? OP_UNUSED : 2'($urandom_range(2));
    if ($urandom_range(9) < 4) o.op = OP_LIMIT;
    o.sd = 1'($urandom_range(1));
    o.sym = wide ? {$urandom, $urandom} : {32'h5359_4D00, sym_pool[$urandom_range(3)]};
    o.seq = wide ? $urandom : 32'($urandom_range(15)) - 32'd8;
    o.qty = wide ? $urandom : 32'($urandom_range(12));
    o.px = wide ? {$urandom, $urandom} : 64'($signed(32'($urandom_range(8)) - 32'd4));
    return o;
  endfunction

  // fill every slot, overflow, then sweep the whole side with one market sell
  task automatic fill_book();
    order_t o;
    for (int i = 0; i < DEPTH + 2; i++) begin
      o = '{OP_LIMIT, 1'b0, 64'hF00D, 32'(i), 32'd1, 64'(i), 1'b0, ST_NONE};
      send_order(o);
    end
    o = '{OP_MARKET, 1'b1, 64'hF00D, 32'd0, 32'(DEPTH), 64'd0, 1'b0, ST_NONE};
    send_order(o);
  endtask

  initial begin
    order_t o;
    int idle_set[4][2] = '{'{0, 0}, '{84, 0}, '{0, 84}, '{9, 9}};
    trade_cnt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      bk_vld[i] = 1'b0;
      bk_qty[i] = '0;
    end
    for (int i = 0; i < 4; i++) sym_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_order(directed[i]);
    drain();  // sender holds off until every result is back
    fill_book();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_set[ph][0];
      recv_stall = idle_set[ph][1];
      for (int k = 0; k < 28; k++) begin
        o = rand_order($urandom_range(19) == 0);
        send_order(o);
      end
    end
    send_idle = 0;
    recv_stall = 0;
    drain();
    repeat (200) @(posedge clk);
    $display("orders %0d, trades checked %0d, status results %0d, mismatches %0d",
             n_orders, n_trades, n_status, errors);
    if (errors == 0 && pending_fills.size() == 0)
      $display("limit_order_book_matcher_tb: done, clean");
    else
      $display("limit_order_book_matcher_tb: done, errors");
    $finish;
  end

  // ~170 orders with their searches and stalls finish well under this
  initial begin
    #20ms;
    $display("limit_order_book_matcher_tb: done, errors");
    $finish;
  end

endmodule
